FILE: rtl/fsr_pkg.sv
// Shared types and constants for the first-fit slot reserver.
// No dependencies; imported by fsr_row_unit, the top level, the checker and the testbench.
package fsr_pkg;

  localparam int START_W   = 12;
  localparam int DUR_W     = 8;
  localparam int GUARD_W   = 8;
  localparam int BAN_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 12;
  localparam int BAN_REGS  = 2;

  localparam int ROW_BITS  = 32;
  localparam int ROW_IDX_W = 5;

  localparam int WINDOW_MINUTES_DEF = 4096;
  localparam int SEARCH_SPAN_DEF    = 1440;
  localparam int BAN_RANGES_DEF     = 2;

  localparam logic [GUARD_W-1:0] GUARD_RESET = 8'd15;

  typedef enum logic [1:0] {
    REQ_CHECK   = 2'd0,
    REQ_FIND    = 2'd1,
    REQ_RESERVE = 2'd2,
    REQ_RELEASE = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GUARD      = 3'd0,
    REG_BAN0_START = 3'd1,
    REG_BAN0_END   = 3'd2,
    REG_BAN1_START = 3'd3,
    REG_BAN1_END   = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CAND,
    S_SCAN_RD,
    S_SCAN_EV,
    S_RMW_RD,
    S_RMW_WR,
    S_RESP
  } state_t;

  typedef struct packed {
    logic                 hit;
    logic [ROW_IDX_W-1:0] idx;
  } scan_res_t;

endpackage

FILE: rtl/fsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/fsr_row_unit.sv
// Shared row unit: builds the bit mask of a minute range inside one
// bitmap row and finds the lowest busy minute under it. Uses fsr_pkg.
module fsr_row_unit
  import fsr_pkg::*;
(
  input  logic [ROW_BITS-1:0]  word_i,
  input  logic [ROW_IDX_W-1:0] lo_bit,
  input  logic [ROW_IDX_W:0]   hi_cnt,
  output logic [ROW_BITS-1:0]  mask,
  output scan_res_t            res
);

  logic [ROW_BITS-1:0] busy;

  always_comb begin
    for (int j = 0; j < ROW_BITS; j++) begin
      mask[j] = ((ROW_IDX_W+1)'(j) >= {1'b0, lo_bit}) && ((ROW_IDX_W+1)'(j) < hi_cnt);
    end
  end

  assign busy = word_i & mask;

  always_comb begin
    res.hit = |busy;
    res.idx = '0;
    for (int j = ROW_BITS - 1; j >= 0; j--) begin
      if (busy[j]) begin
        res.idx = ROW_IDX_W'(j);
      end
    end
  end

endmodule

FILE: rtl/first_fit_slot_reserver.sv
// Reserve/release read and rewrite each touched bitmap row (none when out of window or empty);
// check/find read bitmap rows and move the candidate past each busy minute or banned range.
// Flow: one word in flight; a result waits in S_RESP while the output register holds an
// unaccepted word, and in_ready rises with out_valid as the result loads.
// Reset (synchronous, rst_n low) clears control and the ban registers and sets the guard to
// GUARD_RESET, then a clearing pass writes every bitmap row, with in_ready low.
// Depends on fsr_pkg, fsr_ram, fsr_row_unit.
module first_fit_slot_reserver
  import fsr_pkg::*;
#(
  parameter int WINDOW_MINUTES = WINDOW_MINUTES_DEF,
  parameter int SEARCH_SPAN    = SEARCH_SPAN_DEF,
  parameter int BAN_RANGES     = BAN_RANGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_req_type,
  input  logic [START_W-1:0]   in_start_minute,
  input  logic [DUR_W-1:0]     in_duration,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_ok,
  output logic [START_W-1:0]   out_slot_minute,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam int DEPTH  = (WINDOW_MINUTES + ROW_BITS - 1) / ROW_BITS;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW0    = $clog2(WINDOW_MINUTES + 1024);
  localparam int CW     = (CW0 > 13) ? CW0 : 13;
  localparam int NB_ACT = (BAN_RANGES < BAN_REGS) ? BAN_RANGES : BAN_REGS;
  localparam logic [CW-1:0] WIN_C  = CW'(WINDOW_MINUTES);
  localparam logic [CW-1:0] SPAN_C = CW'(SEARCH_SPAN);
  localparam logic [CW-1:0] ROW_C  = CW'(ROW_BITS);
  localparam logic [AW-1:0] LAST_ROW = AW'(DEPTH - 1);

  state_t state_r, state_nxt;
  req_t   req_r, req_nxt;
  logic [START_W-1:0] start_r, start_nxt;
  logic [DUR_W-1:0]   dur_r, dur_nxt;
  logic [CW-1:0]      cand_r, cand_nxt;
  logic [CW-1:0]      ptr_r, ptr_nxt;
  logic [CW-1:0]      hi_r, hi_nxt;
  logic               res_ok_r, res_ok_nxt;
  logic [START_W-1:0] res_slot_r, res_slot_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic [START_W-1:0] out_slot_r, out_slot_nxt;
  logic [GUARD_W-1:0] guard_r, guard_nxt;
  logic [BAN_W-1:0]   ban_start_r [BAN_REGS];
  logic [BAN_W-1:0]   ban_start_nxt [BAN_REGS];
  logic [BAN_W-1:0]   ban_end_r [BAN_REGS];
  logic [BAN_W-1:0]   ban_end_nxt [BAN_REGS];

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [ROW_BITS-1:0] ram_wdata, ram_rdata;

  logic [CW-1:0] start_c, dur_c, guard_c;
  logic [CW-1:0] cand_end, tried, lim, lo_c, guard_hi, hi_c, ban_jump;
  logic          cand_fail, ban_hit;
  logic [CW-1:0] row_base, row_next, hi_rem, busy_min;
  logic [ROW_IDX_W:0]  hi_cnt;
  logic [AW-1:0]       row_addr;
  logic [ROW_BITS-1:0] row_mask;
  scan_res_t           scan_res;
  logic [CW-1:0]       in_end;
  logic                in_fits, in_rmw;

  fsr_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (DEPTH)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fsr_row_unit u_row (
    .word_i (ram_rdata),
    .lo_bit (ptr_r[ROW_IDX_W-1:0]),
    .hi_cnt (hi_cnt),
    .mask   (row_mask),
    .res    (scan_res)
  );

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_slot_minute = out_slot_r;

  assign in_end  = CW'(in_start_minute) + CW'(in_duration);
  assign in_fits = (in_end <= WIN_C);
  assign in_rmw  = (req_t'(in_req_type) == REQ_RESERVE) ||
                   (req_t'(in_req_type) == REQ_RELEASE);

  assign start_c   = CW'(start_r);
  assign dur_c     = CW'(dur_r);
  assign guard_c   = CW'(guard_r);
  assign cand_end  = cand_r + dur_c;
  assign tried     = cand_r - start_c;
  assign lim       = (req_r == REQ_FIND) ? SPAN_C : CW'(1);
  assign cand_fail = (tried >= lim) || (cand_end > WIN_C);
  assign lo_c      = (cand_r > guard_c) ? (cand_r - guard_c) : '0;
  assign guard_hi  = cand_end + guard_c;
  assign hi_c      = (guard_hi > WIN_C) ? WIN_C : guard_hi;

  // lowest-numbered hitting ban wins; every start from the candidate up to its end also hits it
  always_comb begin
    ban_hit  = 1'b0;
    ban_jump = '0;
    for (int k = NB_ACT - 1; k >= 0; k--) begin
      if ((dur_r != '0) && (ban_end_r[k] > ban_start_r[k]) &&
          (cand_r < CW'(ban_end_r[k])) && (cand_end > CW'(ban_start_r[k]))) begin
        ban_hit  = 1'b1;
        ban_jump = CW'(ban_end_r[k]);
      end
    end
  end

  assign row_base = {ptr_r[CW-1:ROW_IDX_W], {ROW_IDX_W{1'b0}}};
  assign row_next = row_base + ROW_C;
  assign hi_rem   = hi_r - row_base;
  assign hi_cnt   = (hi_rem >= ROW_C) ? (ROW_IDX_W+1)'(ROW_BITS) : hi_rem[ROW_IDX_W:0];
  assign row_addr = ptr_r[ROW_IDX_W +: AW];
  assign busy_min = row_base + CW'(scan_res.idx);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == LAST_ROW) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (!in_rmw) begin
            state_nxt = S_CAND;
          end else if (!in_fits || (in_duration == '0)) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_RMW_RD;
          end
        end
      end
      S_CAND: begin
        if (cand_fail) begin
          state_nxt = S_RESP;
        end else if (!ban_hit) begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_nxt = (ptr_r >= hi_r) ? S_RESP : S_SCAN_EV;
      end
      S_SCAN_EV: begin
        state_nxt = scan_res.hit ? S_CAND : S_SCAN_RD;
      end
      S_RMW_RD: begin
        state_nxt = S_RMW_WR;
      end
      S_RMW_WR: begin
        state_nxt = (row_next >= hi_r) ? S_RESP : S_RMW_RD;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    req_nxt       = req_r;
    start_nxt     = start_r;
    dur_nxt       = dur_r;
    cand_nxt      = cand_r;
    ptr_nxt       = ptr_r;
    hi_nxt        = hi_r;
    res_ok_nxt    = res_ok_r;
    res_slot_nxt  = res_slot_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_slot_nxt  = out_slot_r;
    guard_nxt     = guard_r;
    ban_start_nxt = ban_start_r;
    ban_end_nxt   = ban_end_r;
    ram_we        = 1'b0;
    ram_waddr     = row_addr;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = row_addr;

    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GUARD:      guard_nxt        = cfg_wdata[GUARD_W-1:0];
        REG_BAN0_START: ban_start_nxt[0] = cfg_wdata[BAN_W-1:0];
        REG_BAN0_END:   ban_end_nxt[0]   = cfg_wdata[BAN_W-1:0];
        REG_BAN1_START: ban_start_nxt[1] = cfg_wdata[BAN_W-1:0];
        REG_BAN1_END:   ban_end_nxt[1]   = cfg_wdata[BAN_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt      = req_t'(in_req_type);
          start_nxt    = in_start_minute;
          dur_nxt      = in_duration;
          cand_nxt     = CW'(in_start_minute);
          ptr_nxt      = in_rmw ? CW'(in_start_minute) : '0;
          hi_nxt       = in_end;
          res_ok_nxt   = in_rmw && in_fits;
          res_slot_nxt = in_start_minute;
        end
      end
      S_CAND: begin
        if (!cand_fail) begin
          if (ban_hit) begin
            cand_nxt = ban_jump;
          end else begin
            ptr_nxt = (ptr_r > lo_c) ? ptr_r : lo_c;
            hi_nxt  = hi_c;
          end
        end
      end
      S_SCAN_RD: begin
        if (ptr_r >= hi_r) begin
          res_ok_nxt   = 1'b1;
          res_slot_nxt = cand_r[START_W-1:0];
        end else begin
          ram_re = 1'b1;
        end
      end
      S_SCAN_EV: begin
        if (scan_res.hit) begin
          cand_nxt = busy_min + guard_c + CW'(1);
          ptr_nxt  = busy_min + CW'(1);
        end else begin
          ptr_nxt = row_next;
        end
      end
      S_RMW_RD: begin
        ram_re = 1'b1;
      end
      S_RMW_WR: begin
        ram_we    = 1'b1;
        ram_wdata = (req_r == REQ_RESERVE) ? (ram_rdata | row_mask)
                                           : (ram_rdata & ~row_mask);
        ptr_nxt   = row_next;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_slot_nxt  = res_slot_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      guard_r     <= GUARD_RESET;
      for (int k = 0; k < BAN_REGS; k++) begin
        ban_start_r[k] <= '0;
        ban_end_r[k]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      guard_r     <= guard_nxt;
      ban_start_r <= ban_start_nxt;
      ban_end_r   <= ban_end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    start_r    <= start_nxt;
    dur_r      <= dur_nxt;
    cand_r     <= cand_nxt;
    ptr_r      <= ptr_nxt;
    hi_r       <= hi_nxt;
    res_ok_r   <= res_ok_nxt;
    res_slot_r <= res_slot_nxt;
    out_ok_r   <= out_ok_nxt;
    out_slot_r <= out_slot_nxt;
  end

endmodule

FILE: rtl/fsr_checker.sv
// Port-level assertions for first_fit_slot_reserver, bound to the top level.
// Uses fsr_pkg for field widths.
module fsr_checker
  import fsr_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_ok,
  input logic [START_W-1:0] out_slot_minute
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ok) && $stable(out_slot_minute))
    else $error("result word changed while stalled");

  // reset empties the output and starts the clearing pass
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("not idle-blocked after reset");

  // one word in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second word back to back");

  // a result never appears in the cycle right after an accept
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result appeared too early");

endmodule

bind first_fit_slot_reserver fsr_checker u_fsr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_ok          (out_ok),
  .out_slot_minute (out_slot_minute)
);

FILE: tb/tb_first_fit_slot_reserver.sv
// Self-checking testbench for first_fit_slot_reserver: directed and random
// check/find/reserve/release words against a bitmap predictor, over several guard and ban settings.
// Depends on fsr_pkg and the first_fit_slot_reserver RTL.
module tb_first_fit_slot_reserver
  import fsr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW        = WINDOW_MINUTES_DEF;
  localparam int SEARCH        = SEARCH_SPAN_DEF;
  localparam int DUR_MAX       = (1 << DUR_W) - 1;
  localparam int IDLE_PCT      = 17;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_AT       = 700;
  localparam int HOLD_CYCLES   = 500;
  localparam int LIMIT_CYCLES  = 40_000_000;
  localparam int RANDOM_WORDS  = 280;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(REG_BAN1_END + 1);

  typedef struct {
    req_t                req;
    logic [START_W-1:0]  start;
    logic [DUR_W-1:0]    dur;
  } slot_word_t;

  typedef struct {
    logic                ok;
    logic [START_W-1:0]  slot;
    slot_word_t          word;
  } slot_answer_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_req_type = '0;
  logic [START_W-1:0]   in_start_minute = '0;
  logic [DUR_W-1:0]     in_duration = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_ok;
  logic [START_W-1:0]   out_slot_minute;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  first_fit_slot_reserver uut (.*);

  // predictor state
  bit           busy_map [0:WINDOW-1];
  int unsigned  busy_before [0:WINDOW];
  bit           map_stale = 1'b1;
  int unsigned  gap_min = GUARD_RESET;
  int unsigned  ban_lo [0:BAN_REGS-1] = '{0, 0};
  int unsigned  ban_hi [0:BAN_REGS-1] = '{0, 0};

  slot_word_t   words_pending [$];
  slot_answer_t answers_due [$];
  slot_word_t   cur_word;
  slot_answer_t due;

  int  n_queued = 0;
  int  n_checked = 0;
  int  n_fail = 0;
  int  n_cycles = 0;
  int  n_found = 0;
  int  n_ok = 0;
  int  n_settings = 1;
  int  n_by_op [0:3] = '{0, 0, 0, 0};
  int  hold_left = 0;
  bit  held = 1'b0;
  bit  calm = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void refresh_counts();
    busy_before[0] = 0;
    for (int t = 0; t < WINDOW; t++) busy_before[t + 1] = busy_before[t] + busy_map[t];
    map_stale = 1'b0;
  endfunction

  function automatic bit span_banned(int unsigned s, int unsigned d);
    if (d == 0) return 1'b0;
    for (int k = 0; k < BAN_RANGES_DEF && k < BAN_REGS; k++) begin
      if (ban_hi[k] <= ban_lo[k]) continue;
      if (s < ban_hi[k] && s + d > ban_lo[k]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit span_clear(int unsigned s, int unsigned d);
    int unsigned lo, hi;
    if (s + d > WINDOW) return 1'b0;
    if (map_stale) refresh_counts();
    lo = (s > gap_min) ? s - gap_min : 0;
    hi = s + d + gap_min;
    if (hi > WINDOW) hi = WINDOW;
    if (busy_before[hi] != busy_before[lo]) return 1'b0;
    return !span_banned(s, d);
  endfunction

  function automatic slot_answer_t predict_answer(input slot_word_t w);
    slot_answer_t a;
    int unsigned s, d, t;
    s = w.start;
    d = w.dur;
    a.ok = 1'b0;
    a.slot = w.start;
    a.word = w;
    n_by_op[w.req]++;
    case (w.req)
      REQ_CHECK: a.ok = span_clear(s, d);
      REQ_FIND: begin
        for (int i = 0; i < SEARCH; i++) begin
          t = s + i;
          if (t + d > WINDOW) break;
          if (span_clear(t, d)) begin
            a.ok = 1'b1;
            a.slot = t[START_W-1:0];
            break;
          end
        end
        if (a.ok) n_found++;
      end
      default: begin
        if (s + d <= WINDOW) begin
          for (t = s; t < s + d; t++) busy_map[t] = (w.req == REQ_RESERVE);
          map_stale = 1'b1;
          a.ok = 1'b1;
        end
      end
    endcase
    if (a.ok) n_ok++;
    return a;
  endfunction

  function automatic slot_word_t mk_word(req_t r, int s, int d);
    slot_word_t w;
    w.req = r;
    w.start = s[START_W-1:0];
    w.dur = d[DUR_W-1:0];
    return w;
  endfunction

  function automatic slot_word_t random_word();
    slot_word_t w;
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) w.req = REQ_CHECK;
    else if (pick < 55) w.req = REQ_FIND;
    else if (pick < 83) w.req = REQ_RESERVE;
    else w.req = REQ_RELEASE;
    pick = $urandom_range(99);
    if (pick < 84) w.start = START_W'($urandom_range(WINDOW - 1));
    else if (pick < 95) w.start = START_W'($urandom_range(WINDOW - 1, WINDOW - 1 - DUR_MAX));
    else w.start = pick[0] ? START_W'(WINDOW - 1) : '0;
    pick = $urandom_range(99);
    if (pick < 8) w.dur = '0;
    else if (pick < 16) w.dur = DUR_W'(DUR_MAX);
    else if (pick < 76) w.dur = DUR_W'($urandom_range(24, 1));
    else w.dur = DUR_W'($urandom_range(DUR_MAX - 1, 25));
    return w;
  endfunction

  task automatic push_word(input slot_word_t w);
    words_pending.insert(words_pending.size(), w);
    n_queued++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_GUARD:      gap_min = 32'(val[GUARD_W-1:0]);
      REG_BAN0_START: ban_lo[0] = 32'(val);
      REG_BAN0_END:   ban_hi[0] = 32'(val);
      REG_BAN1_START: ban_lo[1] = 32'(val);
      REG_BAN1_END:   ban_hi[1] = 32'(val);
      default: ;
    endcase
  endtask

  task automatic set_config(int g, int b0lo, int b0hi, int b1lo, int b1hi, bit spare);
    logic [CFG_DAT_W-1:0] junk;
    junk = CFG_DAT_W'($urandom);
    cfg_write(REG_GUARD, {junk[CFG_DAT_W-1:GUARD_W], g[GUARD_W-1:0]});
    cfg_write(REG_BAN0_START, b0lo[BAN_W-1:0]);
    cfg_write(REG_BAN0_END, b0hi[BAN_W-1:0]);
    cfg_write(REG_BAN1_START, b1lo[BAN_W-1:0]);
    cfg_write(REG_BAN1_END, b1hi[BAN_W-1:0]);
    if (spare) begin
      for (int i = REG_SPARE; i < (1 << CFG_IDX_W); i++)
        cfg_write(i[CFG_IDX_W-1:0], CFG_DAT_W'($urandom));
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic drain();
    while (n_checked != n_queued) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_ban(output int lo, output int hi);
    lo = $urandom_range(WINDOW - 1);
    hi = lo + $urandom_range(300);
    if (hi > WINDOW - 1) hi = WINDOW - 1;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) answers_due.insert(answers_due.size(), predict_answer(cur_word));
      if (!in_valid || in_ready) begin
        if (words_pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          cur_word = words_pending.pop_front();
          in_valid <= 1'b1;
          in_req_type <= cur_word.req;
          in_start_minute <= cur_word.start;
          in_duration <= cur_word.dur;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          $error("unexpected result word: ok %0b slot_minute %0d", out_ok, out_slot_minute);
          n_fail++;
        end else begin
          due = answers_due.pop_front();
          n_checked++;
          if (out_ok !== due.ok) begin
            $error("ok: expected %0b, got %0b (%s start %0d duration %0d)", due.ok, out_ok,
                   due.word.req.name(), due.word.start, due.word.dur);
            n_fail++;
          end
          if (out_slot_minute !== due.slot) begin
            $error("slot_minute: expected %0d, got %0d (%s start %0d duration %0d)", due.slot,
                   out_slot_minute, due.word.req.name(), due.word.start, due.word.dur);
            n_fail++;
          end
        end
      end
      if (!held && n_checked >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= LIMIT_CYCLES) begin
      $error("timeout after %0d cycles, %0d of %0d words answered", n_cycles, n_checked,
             n_queued);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int b0lo, b0hi, b1lo, b1hi;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: guard 15, no bans
    push_word(mk_word(REQ_CHECK, 0, 0));
    push_word(mk_word(REQ_CHECK, WINDOW - 1, 1));
    push_word(mk_word(REQ_CHECK, WINDOW - 1, 2));
    push_word(mk_word(REQ_CHECK, WINDOW - DUR_MAX, DUR_MAX));
    push_word(mk_word(REQ_RESERVE, 100, 10));
    push_word(mk_word(REQ_RESERVE, 100, 10));
    push_word(mk_word(REQ_CHECK, 110, 5));
    push_word(mk_word(REQ_CHECK, 125, 5));
    push_word(mk_word(REQ_CHECK, 95, 0));
    push_word(mk_word(REQ_FIND, 90, 5));
    push_word(mk_word(REQ_RESERVE, WINDOW - 6, 6));
    push_word(mk_word(REQ_CHECK, WINDOW - 26, 5));
    push_word(mk_word(REQ_RESERVE, WINDOW - 6, 7));
    push_word(mk_word(REQ_RELEASE, WINDOW - 1, 2));
    push_word(mk_word(REQ_RELEASE, WINDOW - 96, 96));
    push_word(mk_word(REQ_RELEASE, 2000, 5));
    push_word(mk_word(REQ_RESERVE, 50, 0));
    push_word(mk_word(REQ_FIND, WINDOW - 1, DUR_MAX));
    push_word(mk_word(REQ_FIND, WINDOW - 1, 0));
    push_word(mk_word(REQ_RELEASE, 100, 10));
    push_word(mk_word(REQ_FIND, 0, DUR_MAX));
    drain();

    // one live ban and one inverted ban
    set_config(15, 200, 300, 500, 400, 1'b1);
    push_word(mk_word(REQ_CHECK, 250, 1));
    push_word(mk_word(REQ_CHECK, 150, 50));
    push_word(mk_word(REQ_CHECK, 150, 51));
    push_word(mk_word(REQ_CHECK, 450, 10));
    push_word(mk_word(REQ_FIND, 190, 20));
    push_word(mk_word(REQ_CHECK, 250, 0));
    for (int i = 0; i < 100; i++) push_word(random_word());
    drain();

    for (int p = 2; p <= 8; p++) begin
      random_ban(b0lo, b0hi);
      random_ban(b1lo, b1hi);
      case (p)
        2: set_config(0, 0, 0, 777, 777, 1'b0);
        3: set_config(255, b0lo, b0hi, 0, 0, 1'b0);
        4: set_config($urandom_range(40, 1), 0, WINDOW - 1, b1lo, b1hi, 1'b0);
        5: set_config(15, b0lo, b0hi, b1lo, b1hi, 1'b0);
        6: set_config(1, WINDOW - 96, WINDOW - 1, 0, 50, 1'b0);
        7: set_config($urandom_range(255), b0lo, b0hi, b1lo, b1hi, 1'b1);
        default: set_config(GUARD_RESET, 0, 0, 0, 0, 1'b0);
      endcase
      calm = (p == 5);
      // sweep the bitmap clean so every setting starts from a sparse map
      for (int s = 0; s < WINDOW; s += DUR_MAX)
        push_word(mk_word(REQ_RELEASE, s, (WINDOW - s < DUR_MAX) ? WINDOW - s : DUR_MAX));
      for (int i = 0; i < RANDOM_WORDS; i++) push_word(random_word());
      drain();
      calm = 1'b0;
    end

    if (answers_due.size() != 0) begin
      $error("%0d expected results never arrived", answers_due.size());
      n_fail++;
    end
    $display("Covered %0d words over %0d register settings: %0d checks, %0d finds (%0d found),",
             n_checked, n_settings, n_by_op[REQ_CHECK], n_by_op[REQ_FIND], n_found);
    $display("%0d reserves, %0d releases; %0d answered ok, %0d cycles.",
             n_by_op[REQ_RESERVE], n_by_op[REQ_RELEASE], n_ok, n_cycles);
    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/fsr_pkg.sv
rtl/fsr_ram.sv
rtl/fsr_row_unit.sv
rtl/first_fit_slot_reserver.sv
rtl/fsr_checker.sv
tb/tb_first_fit_slot_reserver.sv
